/* design/lpi_pkg.sv */
// shared types and constants for the line-plane intersection pipeline
// no dependencies; imported by lpi_div and line_plane_intersection
package lpi_pkg;

  localparam int unsigned QuotW = 32;   // quotient bits, one per divider step
  localparam int unsigned DenW  = 64;   // magnitude of the denominator
  localparam int unsigned NumW  = 81;   // magnitude of the numerator after the q16 shift

  localparam logic [31:0] SatPos = 32'h7fff_ffff;
  localparam logic [31:0] SatNeg = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] plane_point_x;
    logic signed [31:0] plane_point_y;
    logic signed [31:0] plane_point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] line_point_x;
    logic signed [31:0] line_point_y;
    logic signed [31:0] line_point_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
  } lpi_in_t;

  typedef struct packed {
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               parallel_flag;
    logic               overflow_flag;
  } lpi_out_t;

  // what rides alongside the divider
  typedef struct packed {
    logic [2:0][31:0] lp;
    logic [2:0][31:0] dv;
    logic             neg;
    logic             par;
    logic             ovf;
  } lpi_side_t;

endpackage

/* design/lpi_div.sv */
// pipelined restoring divider, one quotient bit per stage
// depends on lpi_pkg (widths, side payload type)
module lpi_div import lpi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DenW-1:0]   rem_i,
  input  logic [QuotW-1:0]  low_i,
  input  logic [DenW-1:0]   den_i,
  input  lpi_side_t         side_i,
  output logic              valid_o,
  output logic [QuotW-1:0]  quot_o,
  output lpi_side_t         side_o
);

  logic              valid_q [QuotW];
  logic [DenW-1:0]   rem_q   [QuotW];
  logic [QuotW-1:0]  low_q   [QuotW];
  logic [DenW-1:0]   den_q   [QuotW];
  logic [QuotW-1:0]  quot_q  [QuotW];
  lpi_side_t         side_q  [QuotW];

  for (genvar k = 0; k < QuotW; k++) begin : g_step
    logic             valid_in;
    logic [DenW-1:0]  rem_in;
    logic [QuotW-1:0] low_in;
    logic [DenW-1:0]  den_in;
    logic [QuotW-1:0] quot_in;
    lpi_side_t        side_in;
    logic [DenW+1:0]  diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = rem_i;
      assign low_in   = low_i;
      assign den_in   = den_i;
      assign quot_in  = '0;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign low_in   = low_q[k-1];
      assign den_in   = den_q[k-1];
      assign quot_in  = quot_q[k-1];
      assign side_in  = side_q[k-1];
    end

    // trial subtract of the shifted partial remainder
    assign diff = {1'b0, rem_in, low_in[QuotW-1]} - {2'b00, den_in};
    assign ge   = ~diff[DenW+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? diff[DenW-1:0] : {rem_in[DenW-2:0], low_in[QuotW-1]};
        low_q[k]  <= {low_in[QuotW-2:0], 1'b0};
        den_q[k]  <= den_in;
        quot_q[k] <= {quot_in[QuotW-2:0], ge};
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

/* design/line_plane_intersection.sv */
// top level: line-plane intersection in signed q16.16, fully pipelined
// depends on lpi_pkg and lpi_div
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o | in_data_i  (lpi_in_t, 12 x q16.16)
//   out     | out_valid_o / out_stall_i| out_data_o (lpi_out_t, hit + flags)
//
// one transaction in per cycle while not frozen, one result out per
// transaction; on its way to the output register it passes five stages of
// subtract, multiply, sum, magnitude and range check, 32 divider stages at
// one quotient bit each, then parameter clamp, multiply and final add/clamp.
// the whole pipeline advances together; it freezes only while a result
// sits in the output register and the sink stalls, so nothing is lost or
// repeated. reset clears the valid bits only.
module line_plane_intersection import lpi_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lpi_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lpi_out_t out_data_o
);

  logic en;

  logic signed [31:0] p_in [3];
  logic signed [31:0] n_in [3];
  logic signed [31:0] l_in [3];
  logic signed [31:0] v_in [3];

  assign p_in[0] = in_data_i.plane_point_x;
  assign p_in[1] = in_data_i.plane_point_y;
  assign p_in[2] = in_data_i.plane_point_z;
  assign n_in[0] = in_data_i.normal_x;
  assign n_in[1] = in_data_i.normal_y;
  assign n_in[2] = in_data_i.normal_z;
  assign l_in[0] = in_data_i.line_point_x;
  assign l_in[1] = in_data_i.line_point_y;
  assign l_in[2] = in_data_i.line_point_z;
  assign v_in[0] = in_data_i.direction_x;
  assign v_in[1] = in_data_i.direction_y;
  assign v_in[2] = in_data_i.direction_z;

  // stage registers
  logic               v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, vo_q;
  logic signed [32:0] w1_q  [3];
  logic signed [31:0] n1_q  [3];
  logic [2:0][31:0]   l1_q, v1d_q, l2_q, v2d_q, l3_q, v3d_q, l4_q, v4d_q;
  logic signed [64:0] pn2_q [3];
  logic signed [63:0] pd2_q [3];
  logic signed [66:0] num3_q;
  logic signed [65:0] den3_q;
  logic               neg4_q, par4_q;
  logic [64:0]        nmag4_q;
  logic [DenW-1:0]    dmag4_q;
  logic [DenW-1:0]    rem5_q, den5_q;
  logic [QuotW-1:0]   low5_q;
  lpi_side_t          side5_q;
  logic signed [31:0] d6_q;
  logic               ovf6_q, par6_q, ovf7_q, par7_q;
  logic [2:0][31:0]   l6_q, v6d_q, l7_q;
  logic signed [63:0] prod7_q [3];
  lpi_out_t           out_q;

  // the pipeline moves unless a finished result is held by the sink
  assign en         = ~(vo_q & out_stall_i);
  assign in_stall_o = ~en;

  // stage 1: w = p - l
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        w1_q[i]  <= 33'(p_in[i]) - 33'(l_in[i]);
        n1_q[i]  <= n_in[i];
        l1_q[i]  <= l_in[i];
        v1d_q[i] <= v_in[i];
      end
    end
  end

  // stage 2: six products
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pn2_q[i] <= w1_q[i] * 65'(n1_q[i]);
        pd2_q[i] <= $signed(v1d_q[i]) * n1_q[i];
      end
      l2_q  <= l1_q;
      v2d_q <= v1d_q;
    end
  end

  // stage 3: exact q32.32 dot products
  always_ff @(posedge clk_i) begin
    if (en) begin
      num3_q <= 67'(pn2_q[0]) + 67'(pn2_q[1]) + 67'(pn2_q[2]);
      den3_q <= 66'(pd2_q[0]) + 66'(pd2_q[1]) + 66'(pd2_q[2]);
      l3_q   <= l2_q;
      v3d_q  <= v2d_q;
    end
  end

  // stage 4: sign-magnitude split, parallel detect
  logic [66:0] num_abs;
  logic [65:0] den_abs;
  assign num_abs = num3_q[66] ? 67'(-num3_q) : 67'(num3_q);
  assign den_abs = den3_q[65] ? 66'(-den3_q) : 66'(den3_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg4_q  <= num3_q[66] ^ den3_q[65];
      par4_q  <= (den3_q == '0);
      nmag4_q <= num_abs[64:0];
      dmag4_q <= den_abs[DenW-1:0];
      l4_q    <= l3_q;
      v4d_q   <= v3d_q;
    end
  end

  // stage 5: quotient range check and divider seed
  logic [NumW-1:0] nsh;
  logic [DenW-1:0] nhi;
  assign nsh = {nmag4_q, 16'h0000};
  assign nhi = DenW'(nsh[NumW-1:QuotW]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem5_q      <= nhi;
      low5_q      <= nsh[QuotW-1:0];
      den5_q      <= dmag4_q;
      side5_q.lp  <= l4_q;
      side5_q.dv  <= v4d_q;
      side5_q.neg <= neg4_q;
      side5_q.par <= par4_q;
      // quotient needs more than 32 bits
      side5_q.ovf <= (nhi >= dmag4_q);
    end
  end

  logic             div_valid;
  logic [QuotW-1:0] div_quot;
  lpi_side_t        div_side;

  lpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v5_q),
    .rem_i   (rem5_q),
    .low_i   (low5_q),
    .den_i   (den5_q),
    .side_i  (side5_q),
    .valid_o (div_valid),
    .quot_o  (div_quot),
    .side_o  (div_side)
  );

  // stage 6: clamp the line parameter
  logic [31:0] lim;
  logic        dsat;
  logic [31:0] dmag;
  assign lim  = div_side.neg ? SatNeg : SatPos;
  assign dsat = div_side.ovf | (div_quot > lim);
  assign dmag = dsat ? lim : div_quot;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d6_q   <= div_side.neg ? -dmag : dmag;
      ovf6_q <= dsat;
      par6_q <= div_side.par;
      l6_q   <= div_side.lp;
      v6d_q  <= div_side.dv;
    end
  end

  // stage 7: d * v
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        prod7_q[i] <= d6_q * $signed(v6d_q[i]);
      end
      ovf7_q <= ovf6_q;
      par7_q <= par6_q;
      l7_q   <= l6_q;
    end
  end

  // stage 8: l * 2^16 + d * v, floor shift, clamp to int32
  logic signed [64:0] t_sum [3];
  logic signed [48:0] h_val [3];
  logic [2:0]         h_sat;
  logic [2:0][31:0]   h_out;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_sum[i] = $signed({{17{l7_q[i][31]}}, l7_q[i], 16'h0000}) + 65'(prod7_q[i]);
      h_val[i] = t_sum[i][64:16];
      h_sat[i] = (h_val[i][48:31] != '0) && (h_val[i][48:31] != '1);
      h_out[i] = h_sat[i] ? (h_val[i][48] ? SatNeg : SatPos) : h_val[i][31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (par7_q) begin
        out_q <= '{hit_x: '0, hit_y: '0, hit_z: '0, parallel_flag: 1'b1,
                   overflow_flag: 1'b0};
      end else begin
        out_q.hit_x         <= h_out[0];
        out_q.hit_y         <= h_out[1];
        out_q.hit_z         <= h_out[2];
        out_q.parallel_flag <= 1'b0;
        out_q.overflow_flag <= ovf7_q | (|h_sat);
      end
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= div_valid;
      v7_q <= v6_q;
      vo_q <= v7_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

  // a parallel line reports the origin and never overflow
  a_par_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.parallel_flag) |->
      (out_data_o.hit_x == 0 && out_data_o.hit_y == 0 && out_data_o.hit_z == 0 &&
       !out_data_o.overflow_flag))
    else $error("parallel result not cleared");

  // an accepted transaction enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v1_q)
    else $error("accepted transaction lost at entry");

  // a held result stays while the pipeline is frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o) && $stable(v7_q)))
    else $error("pipeline moved under a stall");

endmodule
